// File: sv/qbc_pkg.sv
// qbc_pkg: shared widths, pipeline record types, status codes and the
// wide multiply helper for the quintic boundary coefficient block.
// No dependencies.
package qbc_pkg;

  localparam int XW = 32;   // field width
  localparam int WW = 160;  // exact intermediate width, holds t^5
  localparam int DW = 200;  // divider width, holds the 2^33 overflow bound
  localparam int QW = 33;   // quotient bits, one per divider stage
  localparam int NL = 3;    // lanes: c3, c4, c5

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  typedef logic [WW-1:0] wide_t;
  typedef logic [DW-1:0] dwide_t;

  // fields that ride along with a transaction
  typedef struct packed {
    logic [XW-1:0] p0;
    logic [XW-1:0] v0;
    logic [XW-1:0] c2;
    logic          zero;
  } side_t;

  // one restoring-division lane
  typedef struct packed {
    dwide_t        r;
    dwide_t        d;
    logic [QW-1:0] q;
    logic          neg;
    logic          sat;
  } lane_t;

  typedef struct packed {
    side_t            side;
    lane_t [NL-1:0]   lane;
  } div_t;

  typedef struct packed {
    logic                   vld;
    logic [NL-1:0][XW-1:0]  coef;
    side_t                  side;
    logic [1:0]             status;
  } res_t;

  // sign extend a field to the intermediate width
  function automatic wide_t sx(input logic [XW-1:0] x);
    sx = {{(WW-XW){x[XW-1]}}, x};
  endfunction

  // modular product of a wide value and an unsigned 32-bit factor,
  // one 32x32 partial product per limb
  function automatic wide_t mul_t(input wide_t a, input logic [XW-1:0] t);
    wide_t         acc;
    logic [63:0]   p;
    acc = '0;
    for (int i = 0; i < WW / XW; i++) begin
      p   = 64'(a[XW*i +: XW]) * 64'(t);
      acc = acc + (wide_t'(p) << (XW * i));
    end
    mul_t = acc;
  endfunction

endpackage

// File: sv/qbc_front.sv
// qbc_front: five-stage front end, forms h, dv, da products, the three
// numerators and powers of t, then seeds the divider lanes.
// Depends on qbc_pkg.
module qbc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [31:0]       p0,
  input  logic [31:0]       v0,
  input  logic [31:0]       a0,
  input  logic [31:0]       p1,
  input  logic [31:0]       v1,
  input  logic [31:0]       a1,
  input  logic [31:0]       t,
  output logic              out_vld,
  output qbc_pkg::div_t     out_d
);
  import qbc_pkg::*;

  typedef struct packed {
    side_t side; logic [XW-1:0] t;
    wide_t a0t, v0t, t2, dp, dvr, da;
  } s1_t;
  typedef struct packed {
    side_t side; logic [XW-1:0] t;
    wide_t a0t2, dv, dat, t3, dp, v0t;
  } s2_t;
  typedef struct packed {
    side_t side; logic [XW-1:0] t;
    wide_t h, dvt, dat2, t3, t4;
  } s3_t;
  typedef struct packed {
    side_t side;
    wide_t n3, n4, n5, t3, t4, t5;
  } s4_t;

  s1_t s1; s2_t s2; s3_t s3; s4_t s4;
  logic [3:0] vld;

  // seed one lane: num = 2|n| 2^sh + den, divisor 2 den
  function automatic lane_t lane_init(input wide_t n, input wide_t den_t,
                                      input int unsigned sh);
    logic   neg;
    wide_t  mag;
    dwide_t num;
    dwide_t den;
    neg = n[WW-1];
    mag = neg ? (wide_t'(0) - n) : n;
    num = (dwide_t'(mag) << (sh + 1)) + dwide_t'(den_t);
    den = dwide_t'(den_t) << 1;
    lane_init.r   = num;
    lane_init.d   = den << (QW - 1);
    lane_init.q   = '0;
    lane_init.neg = neg;
    lane_init.sat = (num >= (den << QW));
  endfunction

  // c2 is half the start acceleration, rounded away from zero
  logic [32:0] a0_abs;
  logic [32:0] half;
  always_comb begin
    a0_abs = a0[31] ? (33'd0 - {1'b1, a0}) : {1'b0, a0};
    half   = (a0_abs + 33'd1) >> 1;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[2:0], in_vld};
      out_vld <= vld[3];
    end
  end

  // stage 1: differences and first products
  always_ff @(posedge clk) begin
    s1.side.p0   <= p0;
    s1.side.v0   <= v0;
    s1.side.c2   <= a0[31] ? (32'd0 - half[31:0]) : half[31:0];
    s1.side.zero <= (t == 32'd0);
    s1.t   <= t;
    s1.a0t <= mul_t(sx(a0), t);
    s1.v0t <= mul_t(sx(v0), t);
    s1.t2  <= mul_t(wide_t'(t), t);
    s1.dp  <= sx(p1) - sx(p0);
    s1.dvr <= sx(v1) - sx(v0);
    s1.da  <= sx(a1) - sx(a0);
  end

  // stage 2: a0 t^2, dv, da t, t^3
  always_ff @(posedge clk) begin
    s2.side <= s1.side;
    s2.t    <= s1.t;
    s2.a0t2 <= mul_t(s1.a0t, s1.t);
    s2.dv   <= (s1.dvr << 16) - s1.a0t;
    s2.dat  <= mul_t(s1.da, s1.t);
    s2.t3   <= mul_t(s1.t2, s1.t);
    s2.dp   <= s1.dp;
    s2.v0t  <= s1.v0t;
  end

  // stage 3: h, dv t, da t^2, t^4
  always_ff @(posedge clk) begin
    s3.side <= s2.side;
    s3.t    <= s2.t;
    s3.h    <= (s2.dp << 33) - (s2.v0t << 17) - s2.a0t2;
    s3.dvt  <= mul_t(s2.dv, s2.t);
    s3.dat2 <= mul_t(s2.dat, s2.t);
    s3.t3   <= s2.t3;
    s3.t4   <= mul_t(s2.t3, s2.t);
  end

  // stage 4: numerators by shift-add, t^5
  always_ff @(posedge clk) begin
    s4.side <= s3.side;
    s4.n3   <= (s3.h << 3) + (s3.h << 1) - (s3.dvt << 3) + s3.dat2;
    s4.n4   <= (s3.dvt << 4) - (s3.dvt << 1) - (s3.h << 4) + s3.h
               - (s3.dat2 << 1);
    s4.n5   <= (s3.h << 2) + (s3.h << 1) - (s3.dvt << 2) - (s3.dvt << 1)
               + s3.dat2;
    s4.t3   <= s3.t3;
    s4.t4   <= s3.t4;
    s4.t5   <= mul_t(s3.t4, s3.t);
  end

  // stage 5: divider seeds and overflow bound
  always_ff @(posedge clk) begin
    out_d.side    <= s4.side;
    out_d.lane[0] <= lane_init(s4.n3, s4.t3, 15);
    out_d.lane[1] <= lane_init(s4.n4, s4.t4, 31);
    out_d.lane[2] <= lane_init(s4.n5, s4.t5, 47);
  end

endmodule

// File: sv/qbc_div_stage.sv
// qbc_div_stage: one registered restoring-division step on all lanes.
// Depends on qbc_pkg.
module qbc_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  qbc_pkg::div_t in_d,
  output logic          out_vld,
  output qbc_pkg::div_t out_d
);
  import qbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  // compare, subtract, shift divisor down one place
  always_ff @(posedge clk) begin
    out_d.side <= in_d.side;
    for (int k = 0; k < NL; k++) begin
      if (in_d.lane[k].r >= in_d.lane[k].d) begin
        out_d.lane[k].r <= in_d.lane[k].r - in_d.lane[k].d;
        out_d.lane[k].q <= {in_d.lane[k].q[QW-2:0], 1'b1};
      end else begin
        out_d.lane[k].r <= in_d.lane[k].r;
        out_d.lane[k].q <= {in_d.lane[k].q[QW-2:0], 1'b0};
      end
      out_d.lane[k].d   <= in_d.lane[k].d >> 1;
      out_d.lane[k].neg <= in_d.lane[k].neg;
      out_d.lane[k].sat <= in_d.lane[k].sat;
    end
  end

endmodule

// File: sv/qbc_divider.sv
// qbc_divider: chain of division steps, then sign, saturation and status.
// Depends on qbc_pkg and qbc_div_stage.
module qbc_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  qbc_pkg::div_t in_d,
  output qbc_pkg::res_t res
);
  import qbc_pkg::*;

  logic [QW:0] pv;
  div_t        pd [QW+1];

  assign pv[0] = in_vld;
  assign pd[0] = in_d;

  // one stage per quotient bit
  for (genvar g = 0; g < QW; g++) begin : g_step
    qbc_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (pv[g]),
      .in_d    (pd[g]),
      .out_vld (pv[g+1]),
      .out_d   (pd[g+1])
    );
  end

  // apply sign, clamp, pick status
  logic [NL-1:0][XW-1:0] coef;
  logic [NL-1:0]         over;
  logic [QW-1:0]         limit;
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      limit   = pd[QW].lane[k].neg ? {1'b0, 32'h8000_0000} : {1'b0, 32'h7FFF_FFFF};
      over[k] = pd[QW].lane[k].sat || (pd[QW].lane[k].q > limit);
      if (pd[QW].side.zero) begin
        coef[k] = '0;
      end else if (over[k]) begin
        coef[k] = pd[QW].lane[k].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        coef[k] = pd[QW].lane[k].neg ? (32'd0 - pd[QW].lane[k].q[XW-1:0])
                                     : pd[QW].lane[k].q[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= pv[QW];
    end
  end

  always_ff @(posedge clk) begin
    res.coef <= coef;
    res.side <= pd[QW].side;
    if (pd[QW].side.zero) begin
      res.status <= STATUS_ZERO;
    end else if (|over) begin
      res.status <= STATUS_SAT;
    end else begin
      res.status <= STATUS_OK;
    end
  end

endmodule

// File: sv/quintic_boundary_coefficients_top.sv
// quintic_boundary_coefficients_top: quintic coefficients from boundary values.
// The path from start to done runs through five front stages for the products,
// 33 division steps (one quotient bit each) and one output stage.
// Throughput one transaction per cycle; busy is always low.
// Synchronous active-high reset clears the valid pipeline only.
// Depends on qbc_pkg, qbc_front, qbc_divider.
module quintic_boundary_coefficients_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] start_position,
  input  logic [31:0] start_velocity,
  input  logic [31:0] start_acceleration,
  input  logic [31:0] end_position,
  input  logic [31:0] end_velocity,
  input  logic [31:0] end_acceleration,
  input  logic [31:0] duration,
  output logic        done,
  output logic [31:0] coef_fifth,
  output logic [31:0] coef_fourth,
  output logic [31:0] coef_third,
  output logic [31:0] coef_second,
  output logic [31:0] coef_first,
  output logic [31:0] coef_zero,
  output logic [1:0]  status
);
  import qbc_pkg::*;

  logic  f_vld;
  div_t  f_d;
  res_t  res;

  assign busy = 1'b0;

  qbc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .p0      (start_position),
    .v0      (start_velocity),
    .a0      (start_acceleration),
    .p1      (end_position),
    .v1      (end_velocity),
    .a1      (end_acceleration),
    .t       (duration),
    .out_vld (f_vld),
    .out_d   (f_d)
  );

  qbc_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .in_vld (f_vld),
    .in_d   (f_d),
    .res    (res)
  );

  assign done        = res.vld;
  assign coef_fifth  = res.coef[2];
  assign coef_fourth = res.coef[1];
  assign coef_third  = res.coef[0];
  assign coef_second = res.side.c2;
  assign coef_first  = res.side.v0;
  assign coef_zero   = res.side.p0;
  assign status      = res.status;

endmodule
